// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define NCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define NCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ncs_pkg.sv =====
// ---------------------------------------------------------------------------
// NiMH charge sequencer package
// Shared constants, register codes, phase type and item structures.
// ---------------------------------------------------------------------------
package ncs_pkg;

  // Time base
  localparam int TICKS_PER_SECOND   = 1000;
  localparam int SECONDS_PER_MINUTE = 60;
  localparam int MS_W  = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int SEC_W = (SECONDS_PER_MINUTE > 1) ? $clog2(SECONDS_PER_MINUTE) : 1;

  // Field widths
  localparam int MV_W    = 16;
  localparam int LIMIT_W = 4;
  localparam int MIN_W   = 7;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // Register reset values
  localparam logic [MV_W-1:0]    RST_PLUG_THRESHOLD = 16'd12000;
  localparam logic [LIMIT_W-1:0] RST_PLUG_LIMIT     = 4'd2;
  localparam logic [LIMIT_W-1:0] RST_UNPLUG_LIMIT   = 4'd6;
  localparam logic [MIN_W-1:0]   RST_TRICKLE_MIN    = 7'd5;
  localparam logic [MIN_W-1:0]   RST_BULK_MIN       = 7'd85;
  localparam logic [POS_W-1:0]   RST_PULSE_ON       = 10'd40;
  localparam logic [POS_W-1:0]   RST_LED_SPLIT      = 10'd500;

  // Run counters saturate here
  localparam logic [LIMIT_W-1:0] RUN_MAX = '1;

  typedef enum logic [IDX_W-1:0] {
    CFG_PLUG_THRESHOLD = 3'd0,
    CFG_PLUG_LIMIT     = 3'd1,
    CFG_UNPLUG_LIMIT   = 3'd2,
    CFG_TRICKLE_MIN    = 3'd3,
    CFG_BULK_MIN       = 3'd4,
    CFG_PULSE_ON       = 3'd5,
    CFG_LED_SPLIT      = 3'd6
  } ncs_cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TRICKLE = 2'd1,
    PH_BULK    = 2'd2
  } ncs_phase_t;

  typedef struct packed {
    logic [MV_W-1:0]    plug_threshold_mv;
    logic [LIMIT_W-1:0] plug_count_limit;
    logic [LIMIT_W-1:0] unplug_count_limit;
    logic [MIN_W-1:0]   trickle_minutes;
    logic [MIN_W-1:0]   bulk_minutes;
    logic [POS_W-1:0]   pulse_on_ms;
    logic [POS_W-1:0]   led_split_ms;
  } ncs_cfg_t;

  typedef struct packed {
    logic            func;
    logic [MV_W-1:0] voltage_mv;
    logic            sample_valid;
    logic            download_active;
  } ncs_item_t;

  typedef struct packed {
    logic charger_on;
    logic led1_on;
    logic led2_on;
    logic charging;
    logic plugged;
    logic charge_done;
  } ncs_result_t;

endpackage

// ===== hdl/ncs_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Configuration registers
// Seven write-only registers, written by index, loaded with defaults on reset.
// ---------------------------------------------------------------------------
module ncs_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [ncs_pkg::IDX_W-1:0] cfg_index,
  input  logic [ncs_pkg::CFG_W-1:0] cfg_data,
  output ncs_pkg::ncs_cfg_t         cfg
);

  ncs_pkg::ncs_cfg_t regs;

  // Load defaults, then take writes by index; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.plug_threshold_mv  <= ncs_pkg::RST_PLUG_THRESHOLD;
      regs.plug_count_limit   <= ncs_pkg::RST_PLUG_LIMIT;
      regs.unplug_count_limit <= ncs_pkg::RST_UNPLUG_LIMIT;
      regs.trickle_minutes    <= ncs_pkg::RST_TRICKLE_MIN;
      regs.bulk_minutes       <= ncs_pkg::RST_BULK_MIN;
      regs.pulse_on_ms        <= ncs_pkg::RST_PULSE_ON;
      regs.led_split_ms       <= ncs_pkg::RST_LED_SPLIT;
    end else if (cfg_write) begin
      unique case (ncs_pkg::ncs_cfg_idx_t'(cfg_index))
        ncs_pkg::CFG_PLUG_THRESHOLD: regs.plug_threshold_mv <= cfg_data;
        ncs_pkg::CFG_PLUG_LIMIT:
          regs.plug_count_limit <= cfg_data[ncs_pkg::LIMIT_W-1:0];
        ncs_pkg::CFG_UNPLUG_LIMIT:
          regs.unplug_count_limit <= cfg_data[ncs_pkg::LIMIT_W-1:0];
        ncs_pkg::CFG_TRICKLE_MIN:
          regs.trickle_minutes <= cfg_data[ncs_pkg::MIN_W-1:0];
        ncs_pkg::CFG_BULK_MIN:
          regs.bulk_minutes <= cfg_data[ncs_pkg::MIN_W-1:0];
        ncs_pkg::CFG_PULSE_ON:
          regs.pulse_on_ms <= cfg_data[ncs_pkg::POS_W-1:0];
        ncs_pkg::CFG_LED_SPLIT:
          regs.led_split_ms <= cfg_data[ncs_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hdl/ncs_debounce.sv =====
// ---------------------------------------------------------------------------
// Supply debounce
// Counts good and bad voltage samples and flips the supply-present flag
// once a run passes its limit.
// ---------------------------------------------------------------------------
module ncs_debounce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  ncs_pkg::ncs_item_t         item,
  input  ncs_pkg::ncs_cfg_t          cfg,
  output logic                       supply_next
);

  logic                        supply_present;
  logic [ncs_pkg::LIMIT_W-1:0] good_run;
  logic [ncs_pkg::LIMIT_W-1:0] bad_run;
  logic                        supply_present_next;
  logic [ncs_pkg::LIMIT_W-1:0] good_run_next;
  logic [ncs_pkg::LIMIT_W-1:0] bad_run_next;
  logic                        take;
  logic                        good;
  logic [ncs_pkg::LIMIT_W-1:0] good_inc;
  logic [ncs_pkg::LIMIT_W-1:0] bad_inc;

  // Only ticks with a fresh sample outside download are debounced
  assign take     = !item.func && item.sample_valid && !item.download_active;
  assign good     = item.voltage_mv >= cfg.plug_threshold_mv;
  assign good_inc = (good_run == ncs_pkg::RUN_MAX) ? good_run : good_run + 1'b1;
  assign bad_inc  = (bad_run == ncs_pkg::RUN_MAX) ? bad_run : bad_run + 1'b1;

  // Update the runs and trip the flag
  always_comb begin
    supply_present_next = supply_present;
    good_run_next       = good_run;
    bad_run_next        = bad_run;
    if (take) begin
      if (supply_present) begin
        bad_run_next = good ? '0 : bad_inc;
        if (bad_run_next > cfg.unplug_count_limit) begin
          supply_present_next = 1'b0;
          bad_run_next        = '0;
        end
      end else begin
        if (good) begin
          bad_run_next  = '0;
          good_run_next = good_inc;
        end else begin
          good_run_next = '0;
        end
        if (good_run_next > cfg.plug_count_limit) begin
          supply_present_next = 1'b1;
          good_run_next       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_present <= 1'b0;
      good_run       <= '0;
      bad_run        <= '0;
    end else if (advance) begin
      supply_present <= supply_present_next;
      good_run       <= good_run_next;
      bad_run        <= bad_run_next;
    end
  end

  assign supply_next = supply_present_next;

endmodule

// ===== hdl/ncs_phase.sv =====
// ---------------------------------------------------------------------------
// Charge phase sequencer
// Runs idle, trickle and bulk phases on millisecond, second and minute
// counters and forms the result of each item.
// ---------------------------------------------------------------------------
module ncs_phase (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  ncs_pkg::ncs_item_t  item,
  input  ncs_pkg::ncs_cfg_t   cfg,
  input  logic                supply_next,
  output ncs_pkg::ncs_result_t result
);

  localparam logic [ncs_pkg::MS_W:0]  MS_WRAP  = (ncs_pkg::MS_W+1)'(ncs_pkg::TICKS_PER_SECOND);
  localparam logic [ncs_pkg::SEC_W:0] SEC_WRAP =
    (ncs_pkg::SEC_W+1)'(ncs_pkg::SECONDS_PER_MINUTE);

  ncs_pkg::ncs_phase_t        phase;
  ncs_pkg::ncs_phase_t        phase_next;
  logic [ncs_pkg::MS_W-1:0]   ms_in_second;
  logic [ncs_pkg::MS_W-1:0]   ms_in_second_next;
  logic [ncs_pkg::SEC_W-1:0]  seconds_in_minute;
  logic [ncs_pkg::SEC_W-1:0]  seconds_in_minute_next;
  logic [ncs_pkg::MIN_W-1:0]  minutes_left;
  logic [ncs_pkg::MIN_W-1:0]  minutes_left_next;
  logic                       done;
  logic [ncs_pkg::MS_W:0]     ms_inc;
  logic [ncs_pkg::SEC_W:0]    sec_inc;
  logic [ncs_pkg::MIN_W-1:0]  min_dec;
  logic [ncs_pkg::POS_W-1:0]  pos;

  assign ms_inc  = {1'b0, ms_in_second} + 1'b1;
  assign sec_inc = {1'b0, seconds_in_minute} + 1'b1;
  assign min_dec = (minutes_left != '0) ? minutes_left - 1'b1 : minutes_left;

  // Next phase and timer state
  always_comb begin
    phase_next             = phase;
    ms_in_second_next      = ms_in_second;
    seconds_in_minute_next = seconds_in_minute;
    minutes_left_next      = minutes_left;
    done                   = 1'b0;
    if (item.func) begin
      // Start: only from idle with supply present
      if (phase == ncs_pkg::PH_IDLE && supply_next) begin
        ms_in_second_next      = '0;
        seconds_in_minute_next = '0;
        if (cfg.trickle_minutes != '0) begin
          phase_next        = ncs_pkg::PH_TRICKLE;
          minutes_left_next = cfg.trickle_minutes;
        end else if (cfg.bulk_minutes != '0) begin
          phase_next        = ncs_pkg::PH_BULK;
          minutes_left_next = cfg.bulk_minutes;
        end else begin
          phase_next        = ncs_pkg::PH_IDLE;
          minutes_left_next = '0;
          done              = 1'b1;
        end
      end
    end else if (phase != ncs_pkg::PH_IDLE && !supply_next) begin
      // Supply lost: abort
      phase_next             = ncs_pkg::PH_IDLE;
      minutes_left_next      = '0;
      ms_in_second_next      = '0;
      seconds_in_minute_next = '0;
      done                   = 1'b1;
    end else if (phase != ncs_pkg::PH_IDLE) begin
      // Advance the time base
      ms_in_second_next = ms_inc[ncs_pkg::MS_W-1:0];
      if (ms_inc >= MS_WRAP) begin
        ms_in_second_next      = '0;
        seconds_in_minute_next = sec_inc[ncs_pkg::SEC_W-1:0];
        if (sec_inc >= SEC_WRAP) begin
          seconds_in_minute_next = '0;
          minutes_left_next      = min_dec;
          if (min_dec == '0) begin
            if (phase == ncs_pkg::PH_TRICKLE && cfg.bulk_minutes != '0) begin
              phase_next        = ncs_pkg::PH_BULK;
              minutes_left_next = cfg.bulk_minutes;
            end else begin
              phase_next        = ncs_pkg::PH_IDLE;
              minutes_left_next = '0;
              done              = 1'b1;
            end
          end
        end
      end
    end
  end

  // Outputs use the ms position held before this item; it is zero in idle
  assign pos = ncs_pkg::POS_W'(ms_in_second);

  always_comb begin
    result.charger_on  = 1'b0;
    result.led1_on     = 1'b0;
    result.led2_on     = 1'b0;
    result.charging    = phase_next != ncs_pkg::PH_IDLE;
    result.plugged     = supply_next;
    result.charge_done = done;
    unique case (phase_next)
      ncs_pkg::PH_TRICKLE: begin
        result.charger_on = pos < cfg.pulse_on_ms;
        result.led1_on    = pos < cfg.led_split_ms;
      end
      ncs_pkg::PH_BULK: begin
        result.charger_on = 1'b1;
        result.led1_on    = pos > cfg.led_split_ms;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= ncs_pkg::PH_IDLE;
      ms_in_second      <= '0;
      seconds_in_minute <= '0;
      minutes_left      <= '0;
    end else if (advance) begin
      phase             <= phase_next;
      ms_in_second      <= ms_in_second_next;
      seconds_in_minute <= seconds_in_minute_next;
      minutes_left      <= minutes_left_next;
    end
  end

endmodule

// ===== hdl/nimh_charge_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// NiMH charge sequencer, top level
// Debounced supply detection and a timed trickle/bulk charge sequence,
// driven by millisecond ticks and start commands.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------
//   in      | in_valid/in_ready   | func, voltage_mv, sample_valid,
//           |                     | download_active
//   out     | out_valid/out_ready | charger_on, led1_on, led2_on,
//           |                     | charging, plugged, charge_done
//   cfg     | cfg_write           | cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; an accepted item's result
// is presented after it passes the input register, then the result register.
// Sequencer and debounce state update when an item moves from the input
// register into the result register; that step sets the rate.
// A stalled result holds the result register; the input register still takes
// one more item and then in_ready drops.
// Synchronous reset clears state and loads register defaults.
// ---------------------------------------------------------------------------
module nimh_charge_sequencer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [ncs_pkg::MV_W-1:0]    voltage_mv,
  input  logic                        sample_valid,
  input  logic                        download_active,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        charger_on,
  output logic                        led1_on,
  output logic                        led2_on,
  output logic                        charging,
  output logic                        plugged,
  output logic                        charge_done,
  input  logic                        cfg_write,
  input  logic [ncs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ncs_pkg::CFG_W-1:0]   cfg_data
);

  ncs_pkg::ncs_cfg_t    cfg;
  ncs_pkg::ncs_item_t   item;
  logic                 item_valid;
  ncs_pkg::ncs_result_t result_comb;
  ncs_pkg::ncs_result_t result;
  logic                 advance;
  logic                 supply_next;

  // Move an item forward when the result register is free or drains
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  ncs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.func            <= func;
      item.voltage_mv      <= voltage_mv;
      item.sample_valid    <= sample_valid;
      item.download_active <= download_active;
    end
  end

  ncs_debounce u_debounce (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .cfg         (cfg),
    .supply_next (supply_next)
  );

  ncs_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .cfg         (cfg),
    .supply_next (supply_next),
    .result      (result_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_comb;
    end
  end

  assign charger_on  = result.charger_on;
  assign led1_on     = result.led1_on;
  assign led2_on     = result.led2_on;
  assign charging    = result.charging;
  assign plugged     = result.plugged;
  assign charge_done = result.charge_done;

endmodule

// ===== hdl/ncs_checker.sv =====
// ---------------------------------------------------------------------------
// Port checker
// Watches the top-level result channel for charge-state consistency.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ncs_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic charger_on,
  input logic led1_on,
  input logic led2_on,
  input logic charging,
  input logic plugged,
  input logic charge_done
);

  logic       stalled;
  logic [5:0] status;

  assign stalled = out_valid && !out_ready;
  assign status  = {charger_on, led1_on, led2_on, charging, plugged, charge_done};

  // Current only flows during a charge phase
  `NCS_ASSERT_IMPL(a_on_charging, out_valid && charger_on, charging, "current while idle")

  // A running charge always has supply present
  `NCS_ASSERT_IMPL(a_chg_plugged, out_valid && charging, plugged, "charging while unplugged")

  // The end pulse never comes with a running charge
  `NCS_ASSERT_IMPL(a_done, out_valid && charge_done, !charging && !led1_on, "done mid-charge")

  // LED two stays dark
  `NCS_ASSERT_IMPL(a_led2_dark, out_valid, !led2_on, "led2_on lit")

  // A stalled result holds
  `NCS_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(status), "stalled result changed")

endmodule

bind nimh_charge_sequencer_top ncs_checker u_ncs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .charger_on  (charger_on),
  .led1_on     (led1_on),
  .led2_on     (led2_on),
  .charging    (charging),
  .plugged     (plugged),
  .charge_done (charge_done)
);
